// ===== rtl/core/aupmix_pkg.sv =====
package aupmix_pkg;

  localparam int unsigned DataWidth = 32;

  typedef logic signed [DataWidth-1:0] sample_t;

  localparam sample_t FMax   = 32'sh7fffffff;
  localparam sample_t FMin   = 32'sh80000000;
  localparam sample_t K079   = 32'sd1696512082;
  localparam sample_t KHalf  = 32'sh40000000;

  typedef enum logic [1:0] {
    MODE_STEREO   = 2'd0,
    MODE_SURROUND = 2'd1,
    MODE_FIVE     = 2'd2,
    MODE_SCALED   = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    REG_MODE      = 3'd0,
    REG_ENABLE    = 3'd1,
    REG_IN_GAIN   = 3'd2,
    REG_HEAD_GAIN = 3'd3,
    REG_THRESHOLD = 3'd4,
    REG_RATIO     = 3'd5,
    REG_SOFT_KNEE = 3'd6
  } reg_index_t;

  // Saturate a 34-bit sum into Q1.31.
  function automatic sample_t sat34(input logic signed [33:0] v);
    if (v > 34'sh07fffffff) begin
      return FMax;
    end else if (v < -34'sh080000000) begin
      return FMin;
    end
    return v[31:0];
  endfunction

  function automatic sample_t fadd(input sample_t a, input sample_t b);
    return sat34(34'(a) + 34'(b));
  endfunction

  function automatic sample_t fsub(input sample_t a, input sample_t b);
    return sat34(34'(a) - 34'(b));
  endfunction

  // Q1.31 product; the arithmetic shift floors, only -1 times -1 overflows.
  function automatic sample_t fmul(input sample_t a, input sample_t b);
    logic signed [63:0] p;
    logic signed [32:0] q;
    p = 64'(a) * 64'(b);
    q = p[63:31];
    if (q > 33'sh07fffffff) begin
      return FMax;
    end
    return q[31:0];
  endfunction

endpackage

// ===== rtl/core/aupmix_expander.sv =====
// Expander on one surround path. Coefficients are fixed between frames,
// so they are precomputed from the registers; the sample path is pipelined:
// stage 1 forms a*v, r*v and b*v, stage 2 the a*v*v product and the sum,
// and stage 3 the 0.79 scale followed by the mix add.
module aupmix_expander
  import aupmix_pkg::*;
(
  input  logic    clk,
  input  logic    en,
  input  sample_t v_in,
  input  sample_t mix_in,
  input  logic    bypass,
  input  logic    soft_knee,
  input  sample_t thr,
  input  sample_t ratio,
  input  sample_t off_hard,
  input  sample_t coef_a,
  input  sample_t coef_b,
  input  sample_t coef_cp,
  input  sample_t coef_cn,
  output sample_t surround
);

  logic    in_pos;
  logic    in_neg;
  sample_t neg_thr;
  sample_t av_s1;
  sample_t rv_s1;
  sample_t bv_s1;
  sample_t v_s1;
  sample_t mix_s1;
  logic    pos_s1;
  logic    neg_s1;
  sample_t exp_s2;
  sample_t mix_s2;
  sample_t quad;
  sample_t exp_next;

  assign neg_thr = -thr;
  assign in_pos  = !bypass && (v_in > 0) && (v_in < thr);
  assign in_neg  = !bypass && (v_in < 0) && (v_in > neg_thr);

  // Stage one: first products.
  always_ff @(posedge clk) begin
    if (en) begin
      av_s1  <= fmul(in_neg ? -coef_a : coef_a, v_in);
      rv_s1  <= fmul(ratio, v_in);
      bv_s1  <= fmul(coef_b, v_in);
      v_s1   <= v_in;
      mix_s1 <= mix_in;
      pos_s1 <= in_pos;
      neg_s1 <= in_neg;
    end
  end

  // Characteristic selection.
  always_comb begin
    quad = fmul(av_s1, v_s1);
    if (!pos_s1 && !neg_s1) begin
      exp_next = v_s1;
    end else if (!soft_knee) begin
      exp_next = pos_s1 ? fadd(rv_s1, off_hard) : fsub(rv_s1, off_hard);
    end else begin
      exp_next = fadd(fadd(quad, bv_s1), pos_s1 ? coef_cp : coef_cn);
    end
  end

  // Stages two and three: expanded value, then scale and mix.
  always_ff @(posedge clk) begin
    if (en) begin
      exp_s2   <= exp_next;
      mix_s2   <= mix_s1;
      surround <= fadd(fmul(exp_s2, K079), mix_s2);
    end
  end

endmodule

// ===== rtl/core/audio_upmix_with_expander.sv =====
// Stereo upmixer with an expander on the surround outputs, Q1.31 samples.
// The input channel carries one stereo frame per transaction (left_in,
// right_in); the output channel returns one five-sample frame for each.
// Registers are written through wr_en/wr_index/wr_data; the user must do
// so only while idle, as the block itself does not enforce it. A frame
// passes five register stages, and one frame is taken every cycle in
// which in_ready is high. The stages are input gain, sum and headroom
// multiply, first expander products, the a*v*v product with the knee
// sum, and the 0.79 scale with the mix add. When out_valid is high and
// the receiver holds out_ready low the whole pipeline freezes and
// in_ready falls; nothing is lost or repeated, and in_ready rises again
// once the output moves. Reset empties the pipeline and loads mode 2,
// processing on, both gains one half, hard knee and the default threshold
// and ratio. Soft-knee coefficients are derived from the registers, so
// in_ready stays low after reset or a write until settle reaches zero.
module audio_upmix_with_expander
  import aupmix_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  sample_t     left_in,
  input  sample_t     right_in,
  output logic        out_valid,
  input  logic        out_ready,
  output sample_t     out_left,
  output sample_t     out_right,
  output sample_t     out_center,
  output sample_t     out_left_surround,
  output sample_t     out_right_surround,
  input  logic        wr_en,
  input  logic [2:0]  wr_index,
  input  logic [31:0] wr_data
);

  localparam int unsigned Depth = 5;
  localparam logic [5:0] SettleCycles = 6'd40;

  mode_t   mode;
  logic    enable;
  sample_t in_gain;
  sample_t head_gain;
  sample_t thr;
  sample_t ratio;
  logic    soft_knee;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_FIVE;
      enable    <= 1'b1;
      in_gain   <= 32'sh40000000;
      head_gain <= 32'sh40000000;
      thr       <= 32'sd214748365;
      ratio     <= 32'sd1932735283;
      soft_knee <= 1'b0;
    end else if (wr_en) begin
      case (wr_index)
        REG_MODE:      mode      <= mode_t'(wr_data[1:0]);
        REG_ENABLE:    enable    <= wr_data[0];
        REG_IN_GAIN:   in_gain   <= wr_data;
        REG_HEAD_GAIN: head_gain <= wr_data;
        REG_THRESHOLD: thr       <= {1'b0, wr_data[30:0]};
        REG_RATIO:     ratio     <= {1'b0, wr_data[30:0]};
        REG_SOFT_KNEE: soft_knee <= wr_data[0];
        default: ;
      endcase
    end
  end

  // Coefficient derivation, registered one product per stage.
  logic              bypass;
  sample_t           off_hard;
  sample_t           r2;
  sample_t           t4;
  sample_t           coef_a;
  sample_t           coef_b;
  sample_t           at_q;
  sample_t           at_neg_q;
  sample_t           mb;
  sample_t           coef_cp;
  sample_t           coef_cn;
  logic signed [33:0] t4_wide;
  logic signed [33:0] b_wide;

  assign t4_wide = 34'(thr) <<< 2;
  assign b_wide  = (34'(FMax) + 34'(r2)) >>> 1;

  always_ff @(posedge clk) begin
    bypass   <= (thr == 0) || (ratio == FMax);
    off_hard <= fmul(thr, FMax - ratio);
    r2       <= fmul(ratio, ratio);
    t4       <= (t4_wide > 34'(FMax)) ? FMax : t4_wide[31:0];
    coef_b   <= b_wide[31:0];
    at_q     <= fmul(coef_a, thr);
    at_neg_q <= fmul(-coef_a, thr);
    mb       <= fsub(FMax, coef_b);
    coef_cp  <= fmul(thr, fsub(mb, at_q));
    coef_cn  <= fmul(-thr, fadd(mb, at_neg_q));
  end

  // Restoring divider for a = (max - r2) / t4, one quotient bit a cycle.
  logic        [31:0] num;
  logic        [31:0] div_rem;
  logic        [31:0] div_q;
  logic        [5:0]  div_cnt;
  logic        [32:0] trial;
  sample_t            cfg_t4;
  sample_t            cfg_num;

  assign num   = FMax - r2;
  assign trial = {div_rem, 1'b0} - {1'b0, t4};

  always_ff @(posedge clk) begin
    cfg_t4  <= t4;
    cfg_num <= num;
    if (rst || cfg_t4 != t4 || cfg_num != num) begin
      div_cnt <= '0;
      div_rem <= num;
      div_q   <= '0;
    end else if (div_cnt < 6'd31) begin
      div_cnt <= div_cnt + 6'd1;
      if (!trial[32]) begin
        div_rem <= trial[31:0];
        div_q   <= {div_q[30:0], 1'b1};
      end else begin
        div_rem <= {div_rem[30:0], 1'b0};
        div_q   <= {div_q[30:0], 1'b0};
      end
    end
    coef_a <= (num >= t4) ? FMax : div_q;
  end

  // New frames wait until the derived coefficients have settled.
  logic [5:0] settle;

  always_ff @(posedge clk) begin
    if (rst || wr_en) begin
      settle <= SettleCycles;
    end else if (settle != '0) begin
      settle <= settle - 6'd1;
    end
  end

  // Pipeline control: all stages advance together.
  logic             adv;
  logic [Depth-1:0] vld;

  assign adv       = !out_valid || out_ready;
  assign in_ready  = adv && (settle == '0);
  assign out_valid = vld[Depth-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[Depth-2:0], in_valid && in_ready};
    end
  end

  // Stage one: input gain.
  sample_t ls_s1, rs_s1, l_s1, r_s1;
  // Stage two: centre.
  sample_t ls_s2, rs_s2, ctr_s2, l_s2, r_s2;
  sample_t mix_now;
  sample_t ctr_s3, ctr_s4, l_s3, r_s3, l_s4, r_s4, ls_s3, rs_s3, ls_s4, rs_s4;
  sample_t mix_s3, mix_s4;

  always_ff @(posedge clk) begin
    if (adv) begin
      ls_s1  <= fmul(left_in, in_gain);
      rs_s1  <= fmul(right_in, in_gain);
      l_s1   <= left_in;
      r_s1   <= right_in;
      ls_s2  <= ls_s1;
      rs_s2  <= rs_s1;
      ctr_s2 <= fmul(fadd(ls_s1, rs_s1), head_gain);
      l_s2   <= l_s1;
      r_s2   <= r_s1;
      ctr_s3 <= ctr_s2;
      mix_s3 <= mix_now;
      l_s3   <= l_s2;
      r_s3   <= r_s2;
      ls_s3  <= ls_s2;
      rs_s3  <= rs_s2;
      ctr_s4 <= ctr_s3;
      mix_s4 <= mix_s3;
      l_s4   <= l_s3;
      r_s4   <= r_s3;
      ls_s4  <= ls_s3;
      rs_s4  <= rs_s3;
    end
  end

  assign mix_now = fmul(ctr_s2, KHalf);

  // Surround paths, from stage two (three more stages).
  sample_t sur_l, sur_r;

  aupmix_expander u_exp_l (
    .clk(clk), .en(adv), .v_in(ls_s2), .mix_in(mix_now), .bypass(bypass),
    .soft_knee(soft_knee), .thr(thr), .ratio(ratio), .off_hard(off_hard),
    .coef_a(coef_a), .coef_b(coef_b), .coef_cp(coef_cp), .coef_cn(coef_cn),
    .surround(sur_l)
  );

  aupmix_expander u_exp_r (
    .clk(clk), .en(adv), .v_in(rs_s2), .mix_in(mix_now), .bypass(bypass),
    .soft_knee(soft_knee), .thr(thr), .ratio(ratio), .off_hard(off_hard),
    .coef_a(coef_a), .coef_b(coef_b), .coef_cp(coef_cp), .coef_cn(coef_cn),
    .surround(sur_r)
  );

  // Output selection, on stage five.
  sample_t ctr_s5, mix_s5, l_s5, r_s5, ls_s5, rs_s5;

  always_ff @(posedge clk) begin
    if (adv) begin
      ctr_s5 <= ctr_s4;
      mix_s5 <= mix_s4;
      l_s5   <= l_s4;
      r_s5   <= r_s4;
      ls_s5  <= ls_s4;
      rs_s5  <= rs_s4;
    end
  end

  always_comb begin
    out_left           = mix_s5;
    out_right          = mix_s5;
    out_center         = '0;
    out_left_surround  = '0;
    out_right_surround = '0;
    if (!enable) begin
      out_left  = l_s5;
      out_right = r_s5;
    end else begin
      case (mode)
        MODE_STEREO: ;
        MODE_SURROUND: begin
          out_left_surround  = sur_l;
          out_right_surround = sur_r;
        end
        MODE_FIVE: begin
          out_left_surround  = sur_l;
          out_right_surround = sur_r;
          out_center         = ctr_s5;
        end
        default: begin
          out_left  = ls_s5;
          out_right = rs_s5;
        end
      endcase
    end
  end

endmodule

// ===== verif/tb_top.sv =====
module tb_top;
  import aupmix_pkg::*;

  localparam int unsigned IdleLimit = 20000;
  localparam int unsigned CfgSettle = 16;

  typedef struct packed {
    sample_t left;
    sample_t right;
    sample_t center;
    sample_t ls;
    sample_t rs;
  } frame_out_t;

  // Directed rows: input frame, plus an optional typed-in expected frame.
  typedef struct {
    sample_t    l;
    sample_t    r;
    logic       known;
    frame_out_t want;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  sample_t     left_in = '0;
  sample_t     right_in = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  sample_t     out_left;
  sample_t     out_right;
  sample_t     out_center;
  sample_t     out_left_surround;
  sample_t     out_right_surround;
  logic        wr_en = 1'b0;
  logic [2:0]  wr_index = '0;
  logic [31:0] wr_data = '0;

  // Shadow copy of the configuration registers.
  mode_t       cfg_mode;
  logic        cfg_enable;
  sample_t     cfg_in_gain;
  sample_t     cfg_head_gain;
  logic [30:0] cfg_threshold;
  logic [30:0] cfg_ratio;
  logic        cfg_soft;

  frame_out_t  pending_frames[$];
  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;
  bit          long_hold = 1'b0;
  bit          hold_req = 1'b0;

  always #5 clk = ~clk;

  audio_upmix_with_expander DUT (.*);

  // Independent Q1.31 arithmetic on 64-bit integers.
  function automatic longint q_sat(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint q_mul(input longint a, input longint b);
    longint p;
    p = a * b;
    return q_sat(p >>> 31);
  endfunction

  function automatic longint expand_sample(input longint v);
    longint t, r, off, r2, t4, num, a, b, cp, cn;
    t = longint'(cfg_threshold);
    r = longint'(cfg_ratio);
    if (t == 0 || r == 64'sd2147483647) return v;
    if (!cfg_soft) begin
      off = q_mul(t, 64'sd2147483647 - r);
      if (v > 0 && v < t) return q_sat(q_mul(r, v) + off);
      if (v < 0 && v > -t) return q_sat(q_mul(r, v) - off);
      return v;
    end
    r2 = q_mul(r, r);
    t4 = t * 4;
    if (t4 > 64'sd2147483647) t4 = 64'sd2147483647;
    num = 64'sd2147483647 - r2;
    a = (num >= t4) ? 64'sd2147483647 : (num * 64'sd2147483648) / t4;
    b = (64'sd2147483647 + r2) >>> 1;
    cp = q_mul(t, q_sat(q_sat(64'sd2147483647 - b) - q_mul(a, t)));
    cn = q_mul(-t, q_sat(q_sat(64'sd2147483647 - b) + q_mul(-a, t)));
    if (v > 0 && v < t)
      return q_sat(q_sat(q_mul(q_mul(a, v), v) + q_mul(b, v)) + cp);
    if (v < 0 && v > -t)
      return q_sat(q_sat(q_mul(q_mul(-a, v), v) + q_mul(b, v)) + cn);
    return v;
  endfunction

  function automatic frame_out_t upmix_frame(input sample_t l, input sample_t r);
    frame_out_t f;
    longint ls, rs, ctr, mix;
    f = '0;
    if (!cfg_enable) begin
      f.left = l;
      f.right = r;
      return f;
    end
    ls = q_mul(longint'(l), longint'(cfg_in_gain));
    rs = q_mul(longint'(r), longint'(cfg_in_gain));
    ctr = q_mul(q_sat(ls + rs), longint'(cfg_head_gain));
    mix = q_mul(ctr, 64'sd1073741824);
    if (cfg_mode == MODE_SCALED) begin
      f.left = sample_t'(ls);
      f.right = sample_t'(rs);
      return f;
    end
    f.left = sample_t'(mix);
    f.right = sample_t'(mix);
    if (cfg_mode != MODE_STEREO) begin
      f.ls = sample_t'(q_sat(q_mul(expand_sample(ls), 64'sd1696512082) + mix));
      f.rs = sample_t'(q_sat(q_mul(expand_sample(rs), 64'sd1696512082) + mix));
    end
    if (cfg_mode == MODE_FIVE) f.center = sample_t'(ctr);
    return f;
  endfunction

  // Wait for the pipeline to drain, then write one register and let it settle.
  task automatic write_reg(input reg_index_t idx, input logic [31:0] val);
    while (pending_frames.size() != 0) @(posedge clk);
    repeat (CfgSettle) @(posedge clk);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= val;
    @(posedge clk);
    wr_en <= 1'b0;
    case (idx)
      REG_MODE:      cfg_mode = mode_t'(val[1:0]);
      REG_ENABLE:    cfg_enable = val[0];
      REG_IN_GAIN:   cfg_in_gain = val;
      REG_HEAD_GAIN: cfg_head_gain = val;
      REG_THRESHOLD: cfg_threshold = val[30:0];
      REG_RATIO:     cfg_ratio = val[30:0];
      REG_SOFT_KNEE: cfg_soft = val[0];
      default: ;
    endcase
    repeat (CfgSettle) @(posedge clk);
  endtask

  // Offer one frame, holding it until the transaction completes.
  task automatic send_frame(input sample_t l, input sample_t r, input logic known,
                            input frame_out_t want);
    frame_out_t pred;
    pred = upmix_frame(l, r);
    if (known && pred !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("directed row disagrees with predictor: typed %h predicted %h",
                 want, pred);
    end
    in_valid <= 1'b1;
    left_in <= l;
    right_in <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_frames.push_back(pred);
  endtask

  task automatic send_random(input int unsigned count);
    int unsigned burst;
    sample_t l, r;
    while (count > 0) begin
      burst = $urandom_range(1, 20);
      while (burst > 0 && count > 0) begin
        case ($urandom_range(0, 5))
          0: l = $urandom_range(0, 1) ? FMax : FMin;
          1: l = sample_t'($urandom_range(0, 400000000)) - 200000000;
          default: l = $urandom;
        endcase
        case ($urandom_range(0, 5))
          0: r = $urandom_range(0, 1) ? FMax : FMin;
          1: r = sample_t'($urandom_range(0, 400000000)) - 200000000;
          default: r = $urandom;
        endcase
        send_frame(l, r, 1'b0, '0);
        burst--;
        count--;
      end
      if ($urandom_range(0, 3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
    in_valid <= 1'b0;
  endtask

  task automatic random_config;
    write_reg(REG_MODE, $urandom_range(0, 3));
    write_reg(REG_ENABLE, $urandom_range(0, 7) != 0);
    write_reg(REG_IN_GAIN, $urandom);
    write_reg(REG_HEAD_GAIN, $urandom);
    write_reg(REG_THRESHOLD,
              $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 600000000));
    write_reg(REG_RATIO, $urandom_range(0, 7) == 0 ? 32'h7fffffff : $urandom);
    write_reg(REG_SOFT_KNEE, $urandom_range(0, 1));
  endtask

  // Receiver: its own stall pattern, plus one long hold-off.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (long_hold) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) < 70);
    end
  end

  // Result checking against the oldest pending frame.
  always @(posedge clk) begin
    frame_out_t got, exp_f;
    if (!rst && out_valid && out_ready) begin
      got = '{out_left, out_right, out_center, out_left_surround, out_right_surround};
      if (pending_frames.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected output frame %h", got);
      end else begin
        exp_f = pending_frames.pop_front();
        if (got !== exp_f) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"frame mismatch: expected L %h R %h C %h LS %h RS %h, ",
                      "got L %h R %h C %h LS %h RS %h"},
                     exp_f.left, exp_f.right, exp_f.center, exp_f.ls, exp_f.rs,
                     got.left, got.right, got.center, got.ls, got.rs);
        end
      end
    end
  end

  // Watchdog on cycles without any transaction.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || wr_en) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Long receiver hold-off while the sender keeps offering frames.
  initial begin
    wait (hold_req);
    @(posedge clk);
    repeat (8) @(posedge clk);
    long_hold = 1'b1;
    repeat (60) @(posedge clk);
    long_hold = 1'b0;
  end

  initial begin
    stim_row_t rows[$];
    frame_out_t z;
    int unsigned phase;
    z = '0;
    cfg_mode = MODE_FIVE;
    cfg_enable = 1'b1;
    cfg_in_gain = 32'sh40000000;
    cfg_head_gain = 32'sh40000000;
    cfg_threshold = 31'd214748365;
    cfg_ratio = 31'd1932735283;
    cfg_soft = 1'b0;

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset defaults: zero in gives zero out everywhere; the other rows carry no typed-in expected frame.
    rows.push_back('{32'sd0, 32'sd0, 1'b1, z});
    rows.push_back('{FMax, FMax, 1'b0, z});
    rows.push_back('{FMin, FMin, 1'b0, z});
    rows.push_back('{FMax, FMin, 1'b0, z});
    rows.push_back('{32'sd1000000, -32'sd1000000, 1'b0, z});
    rows.push_back('{32'sd50000000, 32'sd300000000, 1'b0, z});
    rows.push_back('{-32'sd50000000, -32'sd2, 1'b0, z});
    foreach (rows[i]) send_frame(rows[i].l, rows[i].r, rows[i].known, rows[i].want);
    in_valid <= 1'b0;

    // Processing disabled passes the frame through.
    write_reg(REG_ENABLE, 32'd0);
    send_frame(FMin, FMax, 1'b1, '{FMin, FMax, 32'sd0, 32'sd0, 32'sd0});
    send_frame(32'sh12345678, -32'sd7, 1'b1, '{32'sh12345678, -32'sd7, 32'sd0, 32'sd0, 32'sd0});
    in_valid <= 1'b0;
    write_reg(REG_ENABLE, 32'd1);

    // Minus one times minus one saturates to max in scaled mode, on Ls and Rs.
    write_reg(REG_IN_GAIN, FMin);
    write_reg(REG_MODE, MODE_SCALED);
    send_frame(FMin, FMin, 1'b1, '{FMax, FMax, 32'sd0, 32'sd0, 32'sd0});
    send_frame(32'sd0, FMin, 1'b1, '{32'sd0, FMax, 32'sd0, 32'sd0, 32'sd0});
    in_valid <= 1'b0;

    // Each mode and both knees, with small inputs inside the threshold.
    write_reg(REG_IN_GAIN, FMax);
    write_reg(REG_HEAD_GAIN, FMin);
    foreach (rows[i]) begin
      if (i < 4) begin
        write_reg(REG_MODE, i[1:0]);
        write_reg(REG_SOFT_KNEE, i[0]);
        send_frame(32'sd100000000, -32'sd100000000, 1'b0, z);
        send_frame(32'sd1, -32'sd1, 1'b0, z);
        in_valid <= 1'b0;
      end
    end

    // Expander bypass cases and extreme threshold.
    write_reg(REG_MODE, MODE_SURROUND);
    write_reg(REG_THRESHOLD, 32'd0);
    send_frame(32'sd5000, -32'sd5000, 1'b0, z);
    in_valid <= 1'b0;
    write_reg(REG_THRESHOLD, 32'h7fffffff);
    write_reg(REG_RATIO, 32'h7fffffff);
    send_frame(32'sd5000, -32'sd5000, 1'b0, z);
    in_valid <= 1'b0;
    write_reg(REG_RATIO, 32'd0);
    send_frame(32'sd5000, FMin, 1'b0, z);
    in_valid <= 1'b0;

    // Random phases, each with its own configuration; the third one
    // carries the long receiver hold-off.
    for (phase = 0; phase < 10; phase++) begin
      random_config();
      if (phase == 2) hold_req = 1'b1;
      send_random(70);
    end

    while (pending_frames.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending_frames.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/aupmix_pkg.sv
rtl/core/aupmix_expander.sv
rtl/core/audio_upmix_with_expander.sv
verif/tb_top.sv
